@@ src/selection_graph_event_generator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the event generator checkers.
// ----------------------------------------------------------------------------
`ifndef SELECTION_GRAPH_EVENT_GENERATOR_ASSERT_SVH
`define SELECTION_GRAPH_EVENT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SGEG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgeg assertion failed");

// next-cycle implication
`define SGEG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgeg assertion failed");

`endif

@@ src/sgeg_pkg.sv @@
// ----------------------------------------------------------------------------
// sgeg_pkg
// Types, codes and constants of the selection graph event generator.
// ----------------------------------------------------------------------------
package sgeg_pkg;

    localparam int K_MAX_DEF     = 48;
    localparam int INTR_MAX_DEF  = 8;
    localparam int TIME_FRAC_DEF = 16;

    localparam int LIN_W     = 6;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int LOG_STEPS = 31;

    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECTION_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_BRANCHES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_NODES    = 3'd4;

    typedef enum logic [2:0] {
        K_LEAF   = 3'd0,
        K_COAL   = 3'd1,
        K_SEL    = 3'd2,
        K_SLICE  = 3'd3,
        K_BOUNDS = 3'd4,
        K_DONE   = 3'd5
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_LEAF, S_DONE, S_LOAD, S_NORM, S_SQ, S_LV, S_MULA, S_MULB,
        S_RND, S_DSTART, S_DIV, S_TIME, S_APPLY, S_EVAL, S_EMIT, S_SLB,
        S_SLICE, S_BOUNDS
    } t_state;

    typedef struct packed {
        logic  take;
        logic  start;
        logic  load;
        logic  norm;
        logic  sq;
        logic  lv;
        logic  mula;
        logic  mulb;
        logic  rnd;
        logic  dstart;
        logic  tsum;
        logic  apply;
        logic  eval;
        logic  slice_begin;
        logic  emit;
        t_kind kind;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic [LIN_W-1:0] lineages;
        logic [3:0]       intr;
        logic             running;
        logic             coal;
        logic             ovf;
        logic             slice;
        logic             m_norm;
        logic             div_done;
        logic             out_free;
    } t_stat;

endpackage

@@ src/sgeg_if.sv @@
// ----------------------------------------------------------------------------
// sgeg channel interfaces
// Event input, record output and configuration write channels.
// ----------------------------------------------------------------------------
interface sgeg_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] uniform_choice;
    logic [31:0] uniform_wait;
    modport source (output valid, cmd, uniform_choice, uniform_wait, input ready);
    modport sink   (input valid, cmd, uniform_choice, uniform_wait, output ready);
endinterface

interface sgeg_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [31:0] node_time;
    logic [31:0] block_first;
    logic [31:0] block_end;
    logic [31:0] coal_events;
    logic [31:0] sel_events;
    logic [31:0] slice_count;
    logic        overflow;
    logic        last;
    modport source (output valid, record_kind, node_time, block_first, block_end,
                    coal_events, sel_events, slice_count, overflow, last, input ready);
    modport sink   (input valid, record_kind, node_time, block_first, block_end,
                    coal_events, sel_events, slice_count, overflow, last, output ready);
endinterface

interface sgeg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sgeg_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sgeg_div.sv @@
// ----------------------------------------------------------------------------
// sgeg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgeg_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   n_rem;
    logic [NUM_W-1:0] n_quo;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    always_comb begin
        w_sh  = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        w_ge  = (w_sh >= {1'b0, r_den});
        n_rem = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
        n_quo = {r_quo[NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = !r_busy;
    assign o_quo  = r_quo;
endmodule

@@ src/sgeg_dp.sv @@
// ----------------------------------------------------------------------------
// sgeg_dp
// Datapath: run state, log2 by squaring, rate, time step, record register.
// ----------------------------------------------------------------------------
module sgeg_dp #(
    parameter int K_MAX     = sgeg_pkg::K_MAX_DEF,
    parameter int INTR_MAX  = sgeg_pkg::INTR_MAX_DEF,
    parameter int TIME_FRAC = sgeg_pkg::TIME_FRAC_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sgeg_pkg::t_cmd     i_cmd,
    output sgeg_pkg::t_stat    o_stat,
    input  logic [31:0]        i_u1,
    input  logic [31:0]        i_u2,
    sgeg_cfg_if.sink           i_cfg,
    sgeg_out_if.source         o_out
);
    localparam int LW = sgeg_pkg::LIN_W;
    localparam int SH = 59 - TIME_FRAC;
    localparam int EW = TIME_FRAC + 6;
    localparam int NW = TIME_FRAC + 16;
    localparam int SW = ((NW > 32) ? NW : 32) + 1;
    localparam int RW = $clog2(K_MAX * (K_MAX - 1) * 256 + K_MAX * 65535 + 1);

    // configuration
    logic [5:0]  r_sample;
    logic [15:0] r_sel_rate;
    logic [3:0]  r_extra;
    logic [31:0] r_limit;
    logic [15:0] r_block;

    // run state
    logic [31:0]   r_elapsed, r_nt, r_nib, r_bb, r_coalc, r_selc, r_slc;
    logic [LW-1:0] r_lin;
    logic          r_running;

    // event working registers
    logic [31:0]   r_u1, r_u2;
    logic [3:0]    r_intr;
    logic [RW-1:0] r_pair9, r_rate;
    logic [31:0]   r_m;
    logic [5:0]    r_n;
    logic [30:0]   r_f;
    logic [36:0]   r_lv;
    logic [63:0]   r_p;
    logic [EW-1:0] r_e;
    logic          r_coal, r_ovf, r_slice;
    logic [31:0]   r_t, r_first;

    // record register
    logic          r_o_valid;
    logic [2:0]    r_o_kind;
    logic [31:0]   r_o_time, r_o_first, r_o_end, r_o_coal, r_o_sel, r_o_slice;
    logic          r_o_ovf, r_o_last;

    logic [32:0]          w_x;
    logic [2*LW-1:0]      w_pp;
    logic [63:0]          w_sqp, w_lo, w_hi;
    logic [32:0]          w_s;
    logic [64:0]          w_rs;
    logic [32+RW-1:0]     w_prod;
    logic [NW-1:0]        w_num, w_dt;
    logic [SW-1:0]        w_ts;
    logic                 w_div_done, w_out_free;
    logic [LW-1:0]        w_k0;

    assign w_out_free  = !r_o_valid || o_out.ready;
    assign w_x         = {1'b1, 32'b0} - {1'b0, r_u2};
    assign w_pp        = {{LW{1'b0}}, r_lin} * {{LW{1'b0}}, r_lin - LW'(1)};
    assign w_sqp       = {32'b0, r_m} * {32'b0, r_m};
    assign w_s         = w_sqp[63:31];
    assign w_lo        = {32'b0, r_lv[31:0]} * {36'b0, sgeg_pkg::LN2_Q28};
    assign w_hi        = {59'b0, r_lv[36:32]} * {36'b0, sgeg_pkg::LN2_Q28};
    assign w_rs        = {1'b0, r_p} + (65'd1 << (SH - 1));
    assign w_prod      = {{RW{1'b0}}, r_u1} * {32'b0, r_rate};
    assign w_num       = (NW'(r_e) << 9) + NW'(r_rate >> 1);
    assign w_ts        = SW'(r_elapsed) + SW'(w_dt);
    assign w_k0        = (r_sample > LW'(K_MAX)) ? LW'(K_MAX) : r_sample;

    sgeg_div #(.NUM_W(NW), .DEN_W(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.dstart),
        .i_num   (w_num),
        .i_den   (r_rate),
        .o_done  (w_div_done),
        .o_quo   (w_dt)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample   <= 6'd2;
            r_sel_rate <= '0;
            r_extra    <= '0;
            r_limit    <= '1;
            r_block    <= 16'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sgeg_pkg::REG_SAMPLE_SIZE:    r_sample   <= i_cfg.data[5:0];
                sgeg_pkg::REG_SELECTION_RATE: r_sel_rate <= i_cfg.data[15:0];
                sgeg_pkg::REG_EXTRA_BRANCHES: r_extra    <= i_cfg.data[3:0];
                sgeg_pkg::REG_TIME_LIMIT:     r_limit    <= i_cfg.data;
                sgeg_pkg::REG_BLOCK_NODES:    r_block    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_lin     <= '0;
            r_nt      <= '0;
            r_nib     <= '0;
            r_bb      <= '0;
            r_coalc   <= '0;
            r_selc    <= '0;
            r_slc     <= '0;
            r_running <= 1'b0;
        end else if (i_cmd.start) begin
            r_elapsed <= '0;
            r_lin     <= w_k0;
            r_nt      <= 32'(w_k0);
            r_nib     <= 32'(w_k0);
            r_bb      <= '0;
            r_coalc   <= '0;
            r_selc    <= '0;
            r_slc     <= '0;
            r_running <= (w_k0 > LW'(1)) && (r_limit != 32'd0);
        end else if (i_cmd.apply) begin
            if (r_coal) begin
                r_elapsed <= r_t;
                r_lin     <= r_lin - LW'(1);
                r_coalc   <= r_coalc + 32'd1;
                r_nt      <= r_nt + 32'd1;
                r_nib     <= r_nib + 32'd1;
            end else if (r_ovf) begin
                r_running <= 1'b0;
            end else begin
                r_elapsed <= r_t;
                r_lin     <= r_lin + LW'(1) + LW'(r_intr);
                r_selc    <= r_selc + 32'd1;
                r_nt      <= r_nt + 32'd2 + 32'(r_intr);
                r_nib     <= r_nib + 32'd2 + 32'(r_intr);
            end
        end else if (i_cmd.eval) begin
            r_running <= (r_elapsed < r_limit) && (r_lin > LW'(1));
        end else if (i_cmd.slice_begin) begin
            r_bb <= r_nt;
        end else if (i_cmd.emit && i_cmd.kind == sgeg_pkg::K_SLICE) begin
            r_nt  <= r_nt + 32'd1;
            r_slc <= r_slc + 32'd1;
        end else if (i_cmd.emit && i_cmd.kind == sgeg_pkg::K_BOUNDS) begin
            r_nib <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_u1 <= i_u1;
            r_u2 <= i_u2;
        end
        if (i_cmd.load) begin
            r_m     <= w_x[32] ? 32'h8000_0000 : w_x[31:0];
            r_n     <= w_x[32] ? 6'd32 : 6'd31;
            r_f     <= '0;
            r_intr  <= (r_extra > 4'(INTR_MAX)) ? 4'(INTR_MAX) : r_extra;
            r_pair9 <= RW'({w_pp[2*LW-1:1], 9'b0});
            r_rate  <= RW'({w_pp[2*LW-1:1], 9'b0})
                     + RW'({16'b0, r_lin} * {{LW{1'b0}}, r_sel_rate});
        end
        if (i_cmd.norm) begin
            r_m <= {r_m[30:0], 1'b0};
            r_n <= r_n - 6'd1;
        end
        if (i_cmd.sq) begin
            if (w_s[32]) begin
                r_m <= w_s[32:1];
                r_f <= {r_f[29:0], 1'b1};
            end else begin
                r_m <= w_s[31:0];
                r_f <= {r_f[29:0], 1'b0};
            end
        end
        if (i_cmd.lv) begin
            r_lv <= (37'(6'd32 - r_n) << 31) - 37'(r_f);
        end
        if (i_cmd.mula) begin
            r_p <= w_lo;
        end
        if (i_cmd.mulb) begin
            r_p <= r_p + (w_hi << 32);
        end
        if (i_cmd.rnd) begin
            r_e    <= EW'(w_rs >> SH);
            r_coal <= (w_prod <= {r_pair9, 32'b0});
        end
        if (i_cmd.tsum) begin
            r_t   <= (|w_ts[SW-1:32]) ? 32'hFFFF_FFFF : w_ts[31:0];
            r_ovf <= !r_coal
                && (({1'b0, r_lin} + 7'd1 + {3'b0, r_intr}) > 7'(K_MAX));
        end
        if (i_cmd.eval) begin
            r_slice <= ((r_nib >= 32'(r_block)) && (r_nib >= 32'(r_lin)))
                    || (r_elapsed >= r_limit) || (r_lin == LW'(1));
        end
        if (i_cmd.slice_begin) begin
            r_first <= r_bb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind  <= i_cmd.kind;
            r_o_time  <= (i_cmd.kind == sgeg_pkg::K_SEL) ? r_t : r_elapsed;
            r_o_first <= (i_cmd.kind == sgeg_pkg::K_BOUNDS) ? r_first : 32'd0;
            r_o_end   <= (i_cmd.kind == sgeg_pkg::K_BOUNDS) ? r_nt : 32'd0;
            r_o_coal  <= r_coalc;
            r_o_sel   <= r_selc;
            r_o_slice <= (i_cmd.kind == sgeg_pkg::K_SLICE) ? r_slc + 32'd1 : r_slc;
            r_o_ovf   <= (i_cmd.kind == sgeg_pkg::K_SEL) && r_ovf;
            r_o_last  <= i_cmd.last;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.record_kind = r_o_kind;
    assign o_out.node_time   = r_o_time;
    assign o_out.block_first = r_o_first;
    assign o_out.block_end   = r_o_end;
    assign o_out.coal_events = r_o_coal;
    assign o_out.sel_events  = r_o_sel;
    assign o_out.slice_count = r_o_slice;
    assign o_out.overflow    = r_o_ovf;
    assign o_out.last        = r_o_last;

    always_comb begin
        o_stat.lineages = r_lin;
        o_stat.intr     = r_intr;
        o_stat.running  = r_running;
        o_stat.coal     = r_coal;
        o_stat.ovf      = r_ovf;
        o_stat.slice    = r_slice;
        o_stat.m_norm   = r_m[31];
        o_stat.div_done = w_div_done;
        o_stat.out_free = w_out_free;
    end
endmodule

@@ src/sgeg_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgeg_ctrl
// Sequencer for start runs, event arithmetic and record emission.
// ----------------------------------------------------------------------------
module sgeg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_cmd,
    output logic            o_in_ready,
    input  sgeg_pkg::t_stat i_stat,
    output sgeg_pkg::t_cmd  o_cmd
);
    localparam int CW = sgeg_pkg::CNT_W;

    sgeg_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    w_sel_end;

    assign w_sel_end = CW'(i_stat.intr) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgeg_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = sgeg_pkg::K_LEAF;
        case (r_state)
            sgeg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_cnt      = '0;
                    if (i_in_cmd == sgeg_pkg::CMD_EVENT) begin
                        n_state = i_stat.running ? sgeg_pkg::S_LOAD : sgeg_pkg::S_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = sgeg_pkg::S_LEAF;
                    end
                end
            end
            sgeg_pkg::S_LEAF: begin
                if (r_cnt == i_stat.lineages) begin
                    n_state = sgeg_pkg::S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sgeg_pkg::K_LEAF;
                    o_cmd.last = (r_cnt == i_stat.lineages - CW'(1));
                    n_cnt      = r_cnt + CW'(1);
                    if (o_cmd.last) begin
                        n_state = sgeg_pkg::S_IDLE;
                    end
                end
            end
            sgeg_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sgeg_pkg::K_DONE;
                    o_cmd.last = 1'b1;
                    n_state    = sgeg_pkg::S_IDLE;
                end
            end
            sgeg_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = sgeg_pkg::S_NORM;
            end
            sgeg_pkg::S_NORM: begin
                if (i_stat.m_norm) begin
                    n_cnt   = '0;
                    n_state = sgeg_pkg::S_SQ;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            sgeg_pkg::S_SQ: begin
                o_cmd.sq = 1'b1;
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == CW'(sgeg_pkg::LOG_STEPS - 1)) begin
                    n_state = sgeg_pkg::S_LV;
                end
            end
            sgeg_pkg::S_LV: begin
                o_cmd.lv = 1'b1;
                n_state  = sgeg_pkg::S_MULA;
            end
            sgeg_pkg::S_MULA: begin
                o_cmd.mula = 1'b1;
                n_state    = sgeg_pkg::S_MULB;
            end
            sgeg_pkg::S_MULB: begin
                o_cmd.mulb = 1'b1;
                n_state    = sgeg_pkg::S_RND;
            end
            sgeg_pkg::S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = sgeg_pkg::S_DSTART;
            end
            sgeg_pkg::S_DSTART: begin
                o_cmd.dstart = 1'b1;
                n_state      = sgeg_pkg::S_DIV;
            end
            sgeg_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = sgeg_pkg::S_TIME;
                end
            end
            sgeg_pkg::S_TIME: begin
                o_cmd.tsum = 1'b1;
                n_state    = sgeg_pkg::S_APPLY;
            end
            sgeg_pkg::S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_cnt       = '0;
                n_state     = (!i_stat.coal && i_stat.ovf) ? sgeg_pkg::S_EMIT
                                                           : sgeg_pkg::S_EVAL;
            end
            sgeg_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = sgeg_pkg::S_EMIT;
            end
            sgeg_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.coal) begin
                        o_cmd.kind = sgeg_pkg::K_COAL;
                        o_cmd.last = !i_stat.slice;
                        n_state    = i_stat.slice ? sgeg_pkg::S_SLB : sgeg_pkg::S_IDLE;
                    end else if (i_stat.ovf) begin
                        o_cmd.kind = sgeg_pkg::K_SEL;
                        o_cmd.last = 1'b1;
                        n_state    = sgeg_pkg::S_IDLE;
                    end else begin
                        o_cmd.kind = sgeg_pkg::K_SEL;
                        o_cmd.last = (r_cnt == w_sel_end) && !i_stat.slice;
                        n_cnt      = r_cnt + CW'(1);
                        if (r_cnt == w_sel_end) begin
                            n_state = i_stat.slice ? sgeg_pkg::S_SLB : sgeg_pkg::S_IDLE;
                        end
                    end
                end
            end
            sgeg_pkg::S_SLB: begin
                o_cmd.slice_begin = 1'b1;
                n_cnt             = '0;
                n_state           = sgeg_pkg::S_SLICE;
            end
            sgeg_pkg::S_SLICE: begin
                if (r_cnt == i_stat.lineages) begin
                    n_state = sgeg_pkg::S_BOUNDS;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sgeg_pkg::K_SLICE;
                    n_cnt      = r_cnt + CW'(1);
                end
            end
            sgeg_pkg::S_BOUNDS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = sgeg_pkg::K_BOUNDS;
                    o_cmd.last = 1'b1;
                    n_state    = sgeg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sgeg_pkg::S_IDLE;
            end
        endcase
    end
endmodule

@@ src/selection_graph_event_generator.sv @@
// ----------------------------------------------------------------------------
// selection_graph_event_generator
// Ancestral selection graph event generator, controller plus datapath.
//
//   channel   dir   handshake      word
//   i_in      in    valid/ready    cmd, uniform_choice, uniform_wait
//   o_out     out   valid/ready    one graph record
//   i_cfg     in    valid/ready    register index, write data
//
// A start word emits one leaf record per lineage, then returns to idle.
// An event word runs a normalize shift of s bits (0 to 31), 31 log2 squarings
// on one 32x32 multiplier and a one-bit-per-cycle divider before its first
// record; a refused selection skips the evaluation step. Records then go out
// one per cycle while the output is free, plus the slice-begin and end-of-slice steps when a slice is taken.
// One word is in flight at a time; the record register lets the last record
// wait while the next word is taken. Output stalls hold the sequencer.
// Synchronous active-low reset clears all run state; no clearing pass.
// ----------------------------------------------------------------------------
module selection_graph_event_generator #(
    parameter int K_MAX     = sgeg_pkg::K_MAX_DEF,
    parameter int INTR_MAX  = sgeg_pkg::INTR_MAX_DEF,
    parameter int TIME_FRAC = sgeg_pkg::TIME_FRAC_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgeg_in_if.sink    i_in,
    sgeg_out_if.source o_out,
    sgeg_cfg_if.sink   i_cfg
);
    sgeg_pkg::t_cmd  w_cmd;
    sgeg_pkg::t_stat w_stat;
    logic            w_in_ready;

    assign i_in.ready = w_in_ready;

    sgeg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sgeg_dp #(
        .K_MAX     (K_MAX),
        .INTR_MAX  (INTR_MAX),
        .TIME_FRAC (TIME_FRAC)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_u1    (i_in.uniform_choice),
        .i_u2    (i_in.uniform_wait),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );
endmodule

@@ src/sgeg_checker.sv @@
// ----------------------------------------------------------------------------
// sgeg_checker
// Port-level checks of the event generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "selection_graph_event_generator_assert.svh"

module sgeg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind,
    input logic [31:0] i_out_time,
    input logic        i_out_ovf,
    input logic        i_out_last
);
    `SGEG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_time))
    `SGEG_ASSERT_NOW(a_ovf_sel_last, i_clk, i_rst_n, i_out_valid && i_out_ovf, i_out_kind == sgeg_pkg::K_SEL && i_out_last)
    `SGEG_ASSERT_NOW(a_close_last, i_clk, i_rst_n, i_out_valid && (i_out_kind == sgeg_pkg::K_DONE || i_out_kind == sgeg_pkg::K_BOUNDS), i_out_last)
    `SGEG_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
endmodule

bind selection_graph_event_generator sgeg_checker u_sgeg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.record_kind),
    .i_out_time  (o_out.node_time),
    .i_out_ovf   (o_out.overflow),
    .i_out_last  (o_out.last)
);

@@ tb/selection_graph_event_generator_test.sv @@
// ----------------------------------------------------------------------------
// selection_graph_event_generator_test
// Self-checking bench: start and event words go in on the input channel, a
// predictor of the graph process computes every record, and each record on
// the output channel is checked against the oldest one predicted. Register
// settings change between phases while the block is idle; both channels
// stall at random, with one long output hold-off and a full drain per phase.
// ----------------------------------------------------------------------------
module selection_graph_event_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int K_MAX      = sgeg_pkg::K_MAX_DEF;
    localparam int INTR_MAX   = sgeg_pkg::INTR_MAX_DEF;
    localparam int RND_SHIFT  = 59 - sgeg_pkg::TIME_FRAC_DEF;
    localparam int STALL_LIM  = 6000;
    localparam int HOLD_LONG  = 1500;
    localparam int SETTLE     = 200;

    typedef struct packed {
        sgeg_pkg::t_kind kind;
        logic [31:0]     node_time;
        logic [31:0]     block_first;
        logic [31:0]     block_end;
        logic [31:0]     coal;
        logic [31:0]     sel;
        logic [31:0]     slice;
        logic            ovf;
        logic            last;
    } t_rec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sgeg_in_if  in_ch();
    sgeg_out_if out_ch();
    sgeg_cfg_if cfg_ch();

    selection_graph_event_generator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the registers and run state
    logic [5:0]  c_sample = 6'd2;
    logic [15:0] c_rate   = '0;
    logic [3:0]  c_extra  = '0;
    logic [31:0] c_limit  = '1;
    logic [15:0] c_bnodes = 16'd1;

    logic [31:0] t_now, n_total, n_block, blk_begin, n_coal, n_sel, n_slice;
    int          lin;
    logic        run_on;

    t_rec rec_q[$];
    int   errors = 0;
    bit   idle_en = 1'b1;
    int   hold_req = 0;
    int   quiet_cycles = 0;

    initial begin
        t_now = 0; n_total = 0; n_block = 0; blk_begin = 0;
        n_coal = 0; n_sel = 0; n_slice = 0; lin = 0; run_on = 1'b0;
        in_ch.valid = 1'b0; in_ch.cmd = sgeg_pkg::CMD_START;
        in_ch.uniform_choice = '0; in_ch.uniform_wait = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = sgeg_pkg::REG_SAMPLE_SIZE; cfg_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint unsigned neg_ln_q(input logic [31:0] w);
        longint unsigned x, m, f, lv;
        int n;
        x = 64'h1_0000_0000 - {32'd0, w};
        n = 0;
        while ((x >> (n + 1)) != 0) n++;
        m = (n <= 31) ? (x << (31 - n)) : (x >> (n - 31));
        f = 0;
        for (int i = 0; i < 31; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                f = f | 1;
            end
        end
        lv = (longint'(32 - n) << 31) - f;
        return (lv * longint'(sgeg_pkg::LN2_Q28) + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    endfunction

    function automatic void add_rec(ref int cnt, input sgeg_pkg::t_kind kd,
                                    input logic [31:0] tm, input logic [31:0] bf,
                                    input logic [31:0] be, input logic ov);
        t_rec r;
        r = '{kind: kd, node_time: tm, block_first: bf, block_end: be, coal: n_coal,
              sel: n_sel, slice: n_slice, ovf: ov, last: 1'b0};
        rec_q = {rec_q, r};
        cnt++;
    endfunction

    function automatic void predict_word(input logic cmd, input logic [31:0] u1,
                                         input logic [31:0] u2);
        int cnt, k, intr;
        longint unsigned pair, rate, dt, tsum;
        logic [31:0] first;
        cnt = 0;
        if (cmd == sgeg_pkg::CMD_START) begin
            k = (c_sample > K_MAX) ? K_MAX : c_sample;
            t_now = 0; lin = k; n_total = k; n_block = k; blk_begin = 0;
            n_coal = 0; n_sel = 0; n_slice = 0;
            for (int i = 0; i < k; i++) add_rec(cnt, sgeg_pkg::K_LEAF, 0, 0, 0, 1'b0);
            run_on = (k > 1) && (c_limit > 0);
        end else if (!run_on) begin
            add_rec(cnt, sgeg_pkg::K_DONE, t_now, 0, 0, 1'b0);
        end else begin
            intr = (c_extra > INTR_MAX) ? INTR_MAX : c_extra;
            k = lin;
            pair = longint'(k) * (k - 1) / 2;
            rate = pair * 512 + longint'(k) * c_rate;
            dt = (neg_ln_q(u2) * 512 + rate / 2) / rate;
            tsum = longint'(t_now) + dt;
            if (tsum > 64'hFFFF_FFFF) tsum = 64'hFFFF_FFFF;
            if (longint'(u1) * rate <= ((pair * 512) << 32)) begin
                t_now = tsum[31:0];
                lin = k - 1;
                n_coal++; n_total++; n_block++;
                add_rec(cnt, sgeg_pkg::K_COAL, t_now, 0, 0, 1'b0);
            end else if (k + 1 + intr > K_MAX) begin
                run_on = 1'b0;
                add_rec(cnt, sgeg_pkg::K_SEL, tsum[31:0], 0, 0, 1'b1);
                rec_q[rec_q.size() - 1].last = 1'b1;
                return;
            end else begin
                t_now = tsum[31:0];
                lin = k + 1 + intr;
                n_sel++;
                n_total += 2 + intr; n_block += 2 + intr;
                for (int i = 0; i < 2 + intr; i++)
                    add_rec(cnt, sgeg_pkg::K_SEL, t_now, 0, 0, 1'b0);
            end
            k = lin;
            if ((n_block >= c_bnodes && n_block >= k) || t_now >= c_limit || k == 1) begin
                first = blk_begin;
                blk_begin = n_total;
                for (int i = 0; i < k; i++) begin
                    n_total++; n_slice++;
                    add_rec(cnt, sgeg_pkg::K_SLICE, t_now, 0, 0, 1'b0);
                end
                add_rec(cnt, sgeg_pkg::K_BOUNDS, t_now, first, n_total, 1'b0);
                n_block = 0;
            end
            if (!(t_now < c_limit && k > 1)) run_on = 1'b0;
        end
        if (cnt > 0) rec_q[rec_q.size() - 1].last = 1'b1;
    endfunction

    // record checker
    always @(posedge i_clk) begin
        t_rec got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{kind: sgeg_pkg::t_kind'(out_ch.record_kind), node_time: out_ch.node_time,
                    block_first: out_ch.block_first, block_end: out_ch.block_end,
                    coal: out_ch.coal_events, sel: out_ch.sel_events,
                    slice: out_ch.slice_count, ovf: out_ch.overflow, last: out_ch.last};
            if (rec_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected record kind=%0d time=%h", $time,
                         got.kind, got.node_time);
            end else begin
                want = rec_q.pop_front();
                if (got.kind !== want.kind || got.node_time !== want.node_time ||
                    got.block_first !== want.block_first ||
                    got.block_end !== want.block_end || got.coal !== want.coal ||
                    got.sel !== want.sel || got.slice !== want.slice ||
                    got.ovf !== want.ovf || got.last !== want.last) begin
                    errors++;
                    $display("%0t: record mismatch", $time);
                    $display({"  expected kind=%0d time=%h first=%h end=%h",
                              " c=%0d s=%0d sl=%0d o=%b l=%b"},
                             want.kind, want.node_time, want.block_first, want.block_end,
                             want.coal, want.sel, want.slice, want.ovf, want.last);
                    $display({"  actual   kind=%0d time=%h first=%h end=%h",
                              " c=%0d s=%0d sl=%0d o=%b l=%b"},
                             got.kind, got.node_time, got.block_first, got.block_end,
                             got.coal, got.sel, got.slice, got.ovf, got.last);
                end
            end
        end
    end

    // output ready: random bursts of stall plus a requested long hold-off
    always @(posedge i_clk) begin
        int stall;
        if (hold_req > 0) begin
            hold_req <= hold_req - 1;
            out_ch.ready <= 1'b0;
        end else begin
            stall = 0;
            if (idle_en && $urandom_range(0, 5) == 0) stall = 1;
            out_ch.ready <= !stall;
            if (stall) repeat ($urandom_range(0, 9)) @(posedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM) begin
            $display("selection_graph_event_generator_test: done, errors");
            $finish;
        end
    end

    task automatic send_word(input logic cmd, input logic [31:0] u1, input logic [31:0] u2);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= cmd;
        in_ch.uniform_choice <= u1;
        in_ch.uniform_wait   <= u2;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_word(cmd, u1, u2);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rec_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sgeg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            sgeg_pkg::REG_SAMPLE_SIZE:    c_sample = val[5:0];
            sgeg_pkg::REG_SELECTION_RATE: c_rate   = val[15:0];
            sgeg_pkg::REG_EXTRA_BRANCHES: c_extra  = val[3:0];
            sgeg_pkg::REG_TIME_LIMIT:     c_limit  = val;
            sgeg_pkg::REG_BLOCK_NODES:    c_bnodes = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] ss, input logic [31:0] sr, input logic [31:0] eb,
                            input logic [31:0] tl, input logic [31:0] bn);
        write_reg(sgeg_pkg::REG_SAMPLE_SIZE, ss);
        write_reg(sgeg_pkg::REG_SELECTION_RATE, sr);
        write_reg(sgeg_pkg::REG_EXTRA_BRANCHES, eb);
        write_reg(sgeg_pkg::REG_TIME_LIMIT, tl);
        write_reg(sgeg_pkg::REG_BLOCK_NODES, bn);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rnd32();
        return $urandom();
    endfunction

    task automatic test_reset_defaults();
        send_word(sgeg_pkg::CMD_EVENT, '1, '1);
        send_word(sgeg_pkg::CMD_START, '1, '1);
        send_word(sgeg_pkg::CMD_EVENT, '0, '0);
        send_word(sgeg_pkg::CMD_EVENT, '1, '1);
        drain();
    endtask

    task automatic test_directed();
        set_regs(48, 65535, 8, 32'hFFFF_FFFF, 65535);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        send_word(sgeg_pkg::CMD_EVENT, '1, 32'hFFFF_FFFF);
        send_word(sgeg_pkg::CMD_EVENT, '1, 0);
        drain();
        set_regs(63, 4000, 15, 32'hFFFF_FFFF, 1);
        send_word(sgeg_pkg::CMD_START, rnd32(), rnd32());
        send_word(sgeg_pkg::CMD_EVENT, 0, 32'h8000_0000);
        send_word(sgeg_pkg::CMD_EVENT, 0, 1);
        drain();
        set_regs(4, 300, 2, 32'hFFFF_FFFF, 1);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        send_word(sgeg_pkg::CMD_EVENT, '1, 32'h1234_5678);
        send_word(sgeg_pkg::CMD_EVENT, 32'h8000_0000, 32'hFFFF_0000);
        send_word(sgeg_pkg::CMD_EVENT, 32'h4000_0000, 32'h0000_FFFF);
        drain();
        set_regs(0, 0, 0, 32'hFFFF_FFFF, 1);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        send_word(sgeg_pkg::CMD_EVENT, 0, 0);
        drain();
        set_regs(1, 0, 0, 32'hFFFF_FFFF, 1);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        send_word(sgeg_pkg::CMD_EVENT, 0, 0);
        drain();
        set_regs(5, 100, 1, 0, 1);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        send_word(sgeg_pkg::CMD_EVENT, '1, '1);
        drain();
        set_regs(6, 0, 0, 32'h0000_0100, 3);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        repeat (3) send_word(sgeg_pkg::CMD_EVENT, rnd32(), 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic random_phase(input int items);
        logic [31:0] tl;
        case ($urandom_range(0, 3))
            0: tl = $urandom_range(1, 32'h0004_0000);
            1: tl = rnd32();
            default: tl = 32'hFFFF_FFFF;
        endcase
        set_regs(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 16),
                 ($urandom_range(0, 3) == 0) ? rnd32() : $urandom_range(0, 2000),
                 $urandom_range(0, 15), tl,
                 ($urandom_range(0, 3) == 0) ? rnd32() : $urandom_range(1, 12));
        send_word(sgeg_pkg::CMD_START, rnd32(), rnd32());
        for (int i = 1; i < items; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_word(sgeg_pkg::CMD_START, rnd32(), rnd32());
            else
                send_word(sgeg_pkg::CMD_EVENT, rnd32(), rnd32());
        end
        drain();
    endtask

    task automatic test_random();
        repeat (6) random_phase(39);
    endtask

    task automatic test_backpressure();
        set_regs(12, 512, 3, 32'hFFFF_FFFF, 1);
        send_word(sgeg_pkg::CMD_START, 0, 0);
        hold_req = HOLD_LONG;
        repeat (6) send_word(sgeg_pkg::CMD_EVENT, rnd32(), rnd32());
        drain();
        send_word(sgeg_pkg::CMD_START, 0, 0);
        repeat (3) send_word(sgeg_pkg::CMD_EVENT, rnd32(), rnd32());
        drain();
        repeat (3) send_word(sgeg_pkg::CMD_EVENT, rnd32(), rnd32());
        drain();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        repeat (2) random_phase(20);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_random();
        test_backpressure();
        test_no_idle();
        if (errors == 0 && rec_q.size() == 0) begin
            $display("selection_graph_event_generator_test: done, clean");
        end else begin
            $display("selection_graph_event_generator_test: done, errors");
        end
        $finish;
    end

endmodule
